// ===== src/srbs_pkg.sv =====
// shared constants, codes and types for the sorted record binary search block
package srbs_pkg;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 1024;

    // field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 31;
    localparam int SCORE_W  = 7;
    localparam int MEAN_W   = 8;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;

    // record layout in the table memory: key, second score, first score, mean
    localparam int MEAN_LSB = 0;
    localparam int S1_LSB   = MEAN_LSB + MEAN_W;
    localparam int S2_LSB   = S1_LSB + SCORE_W;
    localparam int KEY_LSB  = S2_LSB + SCORE_W;
    localparam int REC_W    = KEY_LSB + KEY_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // search engine report to the top level
    typedef struct packed {
        logic done;
        logic hit;
    } t_srch_res;

endpackage

// ===== src/srbs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module srbs_ram #(
    parameter int WIDTH = srbs_pkg::REC_W,
    parameter int DEPTH = srbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/srbs_search.sv =====
// binary search engine: one table read and one key compare per halving step
module srbs_search #(
    parameter int TABLE_DEPTH = srbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [srbs_pkg::KEY_W-1:0]     i_key,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] i_count,
    input  logic [srbs_pkg::KEY_W-1:0]     i_rd_key,
    input  logic                           i_res_free,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_mid,
    output logic                           o_busy,
    output srbs_pkg::t_srch_res            o_res
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_MISS = 3'b100
    } t_srch_state;

    t_srch_state r_state, n_state;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hip1, n_hip1;
    logic [IW-1:0] r_mid, n_mid;
    logic [srbs_pkg::KEY_W-1:0] r_key;
    logic [CW:0] w_sum;
    logic w_eq, w_gt, w_step;
    srbs_pkg::t_srch_res w_res;
    logic [IW-1:0] w_rd_addr;

    assign w_eq = (r_key == i_rd_key);
    assign w_gt = (r_key > i_rd_key);

    // next range, next read address and report
    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hip1    = r_hip1;
        n_mid     = r_mid;
        w_rd_addr = r_mid;
        w_res     = '0;
        w_step    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_lo   = '0;
                    n_hip1 = i_count;
                    w_step = 1'b1;
                end
            end
            S_CMP: begin
                if (w_eq) begin
                    if (i_res_free) begin
                        w_res.done = 1'b1;
                        w_res.hit  = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    w_step = 1'b1;
                    if (w_gt) begin
                        n_lo = CW'(r_mid) + CW'(1);
                    end else begin
                        n_hip1 = CW'(r_mid);
                    end
                end
            end
            S_MISS: begin
                if (i_res_free) begin
                    w_res.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // midpoint of the next range, lo to hi inclusive, held as lo and hi + 1
        w_sum = {1'b0, n_lo} + {1'b0, n_hip1} - (CW + 1)'(1);
        // issue the next read, or finish when the range is empty
        if (w_step) begin
            if (n_lo < n_hip1) begin
                n_mid     = w_sum[IW:1];
                w_rd_addr = n_mid;
                n_state   = S_CMP;
            end else begin
                n_state = S_MISS;
            end
        end
    end

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo   <= n_lo;
        r_hip1 <= n_hip1;
        r_mid  <= n_mid;
        if (i_start && r_state == S_IDLE) begin
            r_key <= i_key;
        end
    end

    assign o_rd_addr = w_rd_addr;
    assign o_mid     = r_mid;
    assign o_busy    = (r_state != S_IDLE);
    assign o_res     = w_res;

endmodule

// ===== src/sorted_record_binary_search.sv =====
// top level of the sorted record table with append, clear and binary search
//
//  channel   direction  handshake               payload
//  input     in         i_in_valid / o_in_stall  i_op, i_key, i_first_score, i_second_score
//  output    out        o_out_valid / i_out_stall o_status, o_slot, o_found_first_score,
//                                                 o_found_second_score, o_found_mean
//
// clear, append and unused codes finish in the cycle of their transfer
// a search of n filled slots runs one halving step at a time (at most
// ceil(log2(n + 1)) steps, 11 for 1024 slots), each a read of the single read
// port of the table memory; a miss passes the miss state before its report
// reset zeroes the fill count and output valid and idles the search; the table memory is not cleared
// input stalls while a search runs or while a held result is stalled
module sorted_record_binary_search #(
    parameter int TABLE_DEPTH = srbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [srbs_pkg::OP_W-1:0]          i_op,
    input  logic [srbs_pkg::KEY_W-1:0]         i_key,
    input  logic [srbs_pkg::SCORE_W-1:0]       i_first_score,
    input  logic [srbs_pkg::SCORE_W-1:0]       i_second_score,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [srbs_pkg::STATUS_W-1:0]      o_status,
    output logic [srbs_pkg::SLOT_W-1:0]        o_slot,
    output logic [srbs_pkg::SCORE_W-1:0]       o_found_first_score,
    output logic [srbs_pkg::SCORE_W-1:0]       o_found_second_score,
    output logic [srbs_pkg::MEAN_W-1:0]        o_found_mean
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic r_out_valid, n_out_valid;
    logic [srbs_pkg::STATUS_W-1:0] r_status, n_status;
    logic [srbs_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic [srbs_pkg::SCORE_W-1:0]  r_s1, n_s1, r_s2, n_s2;
    logic [srbs_pkg::MEAN_W-1:0]   r_mean, n_mean;

    logic w_in_acc, w_res_free, w_busy, w_full, w_start, w_we;
    logic [srbs_pkg::REC_W-1:0] w_wdata, w_rdata;
    logic [IW-1:0] w_raddr, w_mid;
    srbs_pkg::t_srch_res w_res;

    // handshake
    assign w_res_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = w_busy || !w_res_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(TABLE_DEPTH));
    assign w_start    = w_in_acc && (i_op == srbs_pkg::OP_SEARCH);
    assign w_we       = w_in_acc && (i_op == srbs_pkg::OP_APPEND) && !w_full;

    // record written on append, mean is the sum of the two scores
    assign w_wdata = {i_key, i_second_score, i_first_score,
                      srbs_pkg::MEAN_W'({1'b0, i_first_score} + {1'b0, i_second_score})};

    srbs_ram #(
        .WIDTH (srbs_pkg::REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    srbs_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_key      (i_key),
        .i_count    (r_count),
        .i_rd_key   (w_rdata[srbs_pkg::KEY_LSB +: srbs_pkg::KEY_W]),
        .i_res_free (w_res_free),
        .o_rd_addr  (w_raddr),
        .o_mid      (w_mid),
        .o_busy     (w_busy),
        .o_res      (w_res)
    );

    // fill count and result register loading
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_slot      = r_slot;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_mean      = r_mean;
        if (w_in_acc && !w_start) begin
            n_out_valid = 1'b1;
            n_status    = srbs_pkg::ST_DONE;
            n_slot      = '0;
            n_s1        = '0;
            n_s2        = '0;
            n_mean      = '0;
            unique case (i_op)
                srbs_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                srbs_pkg::OP_APPEND: begin
                    if (w_full) begin
                        n_status = srbs_pkg::ST_FULL;
                    end else begin
                        n_slot  = srbs_pkg::SLOT_W'(32'(r_count));
                        n_count = r_count + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end else if (w_res.done) begin
            n_out_valid = 1'b1;
            if (w_res.hit) begin
                n_status = srbs_pkg::ST_FOUND;
                n_slot   = srbs_pkg::SLOT_W'(32'(w_mid));
                n_s1     = w_rdata[srbs_pkg::S1_LSB +: srbs_pkg::SCORE_W];
                n_s2     = w_rdata[srbs_pkg::S2_LSB +: srbs_pkg::SCORE_W];
                n_mean   = w_rdata[srbs_pkg::MEAN_LSB +: srbs_pkg::MEAN_W];
            end else begin
                n_status = srbs_pkg::ST_MISS;
                n_slot   = '0;
                n_s1     = '0;
                n_s2     = '0;
                n_mean   = '0;
            end
        end
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
        r_slot   <= n_slot;
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_mean   <= n_mean;
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_status;
    assign o_slot               = r_slot;
    assign o_found_first_score  = r_s1;
    assign o_found_second_score = r_s2;
    assign o_found_mean         = r_mean;

    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // a search report only comes while a search runs and never with an input transfer
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> (w_busy && !w_in_acc))
        else $error("search report outside a search");

    // a hit lies inside the filled slots
    a_hit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.done && w_res.hit) |-> (CW'(w_mid) < r_count))
        else $error("hit outside the filled slots");

    // an accepted append to a table with room advances the fill count by one
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not advance the fill count");

endmodule

// ===== tb/sorted_record_binary_search_tb.sv =====
// self-checking testbench for the sorted record table with append, clear and binary search
module sorted_record_binary_search_tb;

    localparam int DEPTH = srbs_pkg::TABLE_DEPTH_DEF;
    // op code the block leaves unused
    localparam logic [srbs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [srbs_pkg::KEY_W-1:0] KEY_TOP = {srbs_pkg::KEY_W{1'b1}};

    typedef struct packed {
        logic [srbs_pkg::STATUS_W-1:0] status;
        logic [srbs_pkg::SLOT_W-1:0]   slot;
        logic [srbs_pkg::SCORE_W-1:0]  first_score;
        logic [srbs_pkg::SCORE_W-1:0]  second_score;
        logic [srbs_pkg::MEAN_W-1:0]   mean;
    } t_resp;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [srbs_pkg::OP_W-1:0]     i_op;
    logic [srbs_pkg::KEY_W-1:0]    i_key;
    logic [srbs_pkg::SCORE_W-1:0]  i_first_score;
    logic [srbs_pkg::SCORE_W-1:0]  i_second_score;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [srbs_pkg::STATUS_W-1:0] o_status;
    logic [srbs_pkg::SLOT_W-1:0]   o_slot;
    logic [srbs_pkg::SCORE_W-1:0]  o_found_first_score;
    logic [srbs_pkg::SCORE_W-1:0]  o_found_second_score;
    logic [srbs_pkg::MEAN_W-1:0]   o_found_mean;

    // shadow copy of the record table
    logic [srbs_pkg::KEY_W-1:0]   tbl_key    [DEPTH];
    logic [srbs_pkg::SCORE_W-1:0] tbl_first  [DEPTH];
    logic [srbs_pkg::SCORE_W-1:0] tbl_second [DEPTH];
    logic [srbs_pkg::MEAN_W-1:0]  tbl_mean   [DEPTH];
    int                           tbl_fill;

    t_resp pending_resp[$];
    int    fail_cnt  = 0;
    int    sent_cnt  = 0;
    int    hold_left = 0;
    int    resp_wait = 0;
    bit    no_idle   = 1'b0;

    sorted_record_binary_search i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_op                 (i_op),
        .i_key                (i_key),
        .i_first_score        (i_first_score),
        .i_second_score       (i_second_score),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_slot               (o_slot),
        .o_found_first_score  (o_found_first_score),
        .o_found_second_score (o_found_second_score),
        .o_found_mean         (o_found_mean)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // expected response of the table to one item, updating the shadow table
    function automatic t_resp table_response(logic [srbs_pkg::OP_W-1:0] op,
                                             logic [srbs_pkg::KEY_W-1:0] key,
                                             logic [srbs_pkg::SCORE_W-1:0] s1,
                                             logic [srbs_pkg::SCORE_W-1:0] s2);
        t_resp r;
        int    lo;
        int    hi;
        int    mid;
        bit    hit;
        r = '0;
        case (op)
            srbs_pkg::OP_CLEAR: begin
                tbl_fill = 0;
            end
            srbs_pkg::OP_APPEND: begin
                if (tbl_fill >= DEPTH) begin
                    r.status = srbs_pkg::ST_FULL;
                end else begin
                    tbl_key[tbl_fill]    = key;
                    tbl_first[tbl_fill]  = s1;
                    tbl_second[tbl_fill] = s2;
                    tbl_mean[tbl_fill]   = srbs_pkg::MEAN_W'(s1) + srbs_pkg::MEAN_W'(s2);
                    r.status = srbs_pkg::ST_DONE;
                    r.slot   = srbs_pkg::SLOT_W'(tbl_fill);
                    tbl_fill++;
                end
            end
            srbs_pkg::OP_SEARCH: begin
                lo  = 0;
                hi  = tbl_fill - 1;
                mid = 0;
                hit = 1'b0;
                // halve the filled range until the key turns up or the range is empty
                while (lo <= hi && !hit) begin
                    mid = (lo + hi) / 2;
                    if (tbl_key[mid] == key)
                        hit = 1'b1;
                    else if (key > tbl_key[mid])
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
                if (hit) begin
                    r.status       = srbs_pkg::ST_FOUND;
                    r.slot         = srbs_pkg::SLOT_W'(mid);
                    r.first_score  = tbl_first[mid];
                    r.second_score = tbl_second[mid];
                    r.mean         = tbl_mean[mid];
                end else begin
                    r.status = srbs_pkg::ST_MISS;
                end
            end
            default: begin
                r.status = srbs_pkg::ST_DONE;
            end
        endcase
        return r;
    endfunction

    function automatic logic [srbs_pkg::KEY_W-1:0] any_key();
        return srbs_pkg::KEY_W'($urandom);
    endfunction

    // mostly legal scores, now and then above the hundred
    function automatic logic [srbs_pkg::SCORE_W-1:0] any_score();
        if ($urandom_range(0, 7) == 0)
            return srbs_pkg::SCORE_W'($urandom_range(101, 127));
        return srbs_pkg::SCORE_W'($urandom_range(0, 100));
    endfunction

    // key of a filled slot, or a random key on an empty table
    function automatic logic [srbs_pkg::KEY_W-1:0] stored_key();
        if (tbl_fill == 0)
            return any_key();
        return tbl_key[$urandom_range(0, tbl_fill - 1)];
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // one input transfer, with a random gap ahead of it
    task automatic send_item(logic [srbs_pkg::OP_W-1:0] op, logic [srbs_pkg::KEY_W-1:0] key,
                             logic [srbs_pkg::SCORE_W-1:0] s1,
                             logic [srbs_pkg::SCORE_W-1:0] s2);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_key          <= key;
        i_first_score  <= s1;
        i_second_score <= s2;
        do @(posedge i_clk); while (o_in_stall);
        pending_resp.push_back(table_response(op, key, s1, s2));
        sent_cnt++;
    endtask

    // receiver: long hold-off first, then the wait drawn after each transfer
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (resp_wait > 0) begin
                i_out_stall <= 1'b1;
                resp_wait--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // result checking against the oldest expected response
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_resp.size() == 0) begin
                $error("result with nothing expected: status %0d slot %0d", o_status, o_slot);
                fail_cnt++;
            end else begin
                want = pending_resp.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("slot", 32'(want.slot), 32'(o_slot));
                check_field("found_first_score", 32'(want.first_score),
                            32'(o_found_first_score));
                check_field("found_second_score", 32'(want.second_score),
                            32'(o_found_second_score));
                check_field("found_mean", 32'(want.mean), 32'(o_found_mean));
            end
            resp_wait = no_idle ? 0 : $urandom_range(0, 5);
        end
    end

    // empty table, extreme keys and scores, unused code, disorder, duplicates, clear
    task automatic test_special_cases();
        send_item(srbs_pkg::OP_SEARCH, '0, '0, '0);
        send_item(srbs_pkg::OP_SEARCH, KEY_TOP, '1, '1);
        send_item(OP_UNUSED, KEY_TOP, '1, '1);
        send_item(srbs_pkg::OP_APPEND, '0, 7'd0, 7'd0);
        send_item(srbs_pkg::OP_APPEND, 31'd1000, 7'd100, 7'd100);
        send_item(srbs_pkg::OP_APPEND, KEY_TOP - 1'b1, 7'd127, 7'd127);
        send_item(srbs_pkg::OP_APPEND, KEY_TOP, 7'd100, 7'd0);
        send_item(srbs_pkg::OP_SEARCH, '0, '1, '1);
        send_item(srbs_pkg::OP_SEARCH, 31'd1000, '0, '0);
        send_item(srbs_pkg::OP_SEARCH, KEY_TOP - 1'b1, '0, '0);
        send_item(srbs_pkg::OP_SEARCH, KEY_TOP, '0, '0);
        send_item(srbs_pkg::OP_SEARCH, 31'd999, '0, '0);
        send_item(srbs_pkg::OP_SEARCH, 31'd1, '0, '0);
        // out-of-order key, then a repeated one
        send_item(srbs_pkg::OP_APPEND, 31'd500, 7'd1, 7'd126);
        send_item(srbs_pkg::OP_SEARCH, 31'd500, '0, '0);
        send_item(srbs_pkg::OP_APPEND, 31'd1000, 7'd64, 7'd63);
        send_item(srbs_pkg::OP_SEARCH, 31'd1000, '0, '0);
        send_item(OP_UNUSED, '0, '0, '0);
        send_item(srbs_pkg::OP_CLEAR, KEY_TOP, '1, '1);
        send_item(srbs_pkg::OP_SEARCH, 31'd1000, '0, '0);
        send_item(srbs_pkg::OP_APPEND, 31'd7, 7'd3, 7'd3);
        send_item(srbs_pkg::OP_SEARCH, 31'd7, '0, '0);
        send_item(srbs_pkg::OP_CLEAR, '0, '0, '0);
    endtask

    // fill every slot in key order, try two more appends, then search the full table and clear
    task automatic test_full_table();
        logic [srbs_pkg::KEY_W-1:0] k;
        k = srbs_pkg::KEY_W'($urandom_range(0, 255));
        repeat (DEPTH) begin
            send_item(srbs_pkg::OP_APPEND, k, any_score(), any_score());
            k = k + srbs_pkg::KEY_W'($urandom_range(1, 1 << 20));
        end
        send_item(srbs_pkg::OP_APPEND, k, any_score(), any_score());
        send_item(srbs_pkg::OP_APPEND, KEY_TOP, '1, '1);
        send_item(srbs_pkg::OP_SEARCH, tbl_key[0], '0, '0);
        send_item(srbs_pkg::OP_SEARCH, tbl_key[DEPTH - 1], '0, '0);
        send_item(srbs_pkg::OP_SEARCH, tbl_key[DEPTH / 2], '0, '0);
        send_item(srbs_pkg::OP_SEARCH, tbl_key[DEPTH / 2 - 1], '0, '0);
        send_item(srbs_pkg::OP_SEARCH, k, '0, '0);
        send_item(srbs_pkg::OP_SEARCH, tbl_key[3] + 1'b1, '0, '0);
        send_item(srbs_pkg::OP_CLEAR, '0, '0, '0);
    endtask

    // receiver holds off while the sender keeps offering transfers
    task automatic test_back_pressure();
        logic [srbs_pkg::KEY_W-1:0] k;
        k = srbs_pkg::KEY_W'($urandom_range(0, 1000));
        no_idle = 1'b1;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        hold_left = 200;
        repeat (15) begin
            send_item(srbs_pkg::OP_APPEND, k, any_score(), any_score());
            k = k + srbs_pkg::KEY_W'($urandom_range(1, 50));
        end
        repeat (15)
            send_item(srbs_pkg::OP_SEARCH,
                      ($urandom_range(0, 2) == 0) ? any_key() : stored_key(),
                      any_score(), any_score());
        no_idle = 1'b0;
        send_item(srbs_pkg::OP_CLEAR, '0, '0, '0);
    endtask

    // mostly well-formed table builds with searches, some noise in between
    task automatic test_random_traffic();
        int                         target;
        int                         n;
        int                         m;
        int unsigned                step;
        logic [srbs_pkg::KEY_W-1:0] k;
        target = sent_cnt + 150;
        while (sent_cnt < target) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                send_item(srbs_pkg::OP_CLEAR, any_key(), any_score(), any_score());
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 300)
                                                : $urandom_range(1, 24);
                case ($urandom_range(0, 3))
                    0: step = 1;
                    1: step = 3;
                    2: step = 1000;
                    default: step = 1 << 22;
                endcase
                k = srbs_pkg::KEY_W'($urandom_range(0, 1 << 24));
                repeat (n) begin
                    send_item(srbs_pkg::OP_APPEND, k, any_score(), any_score());
                    k = k + srbs_pkg::KEY_W'($urandom_range(1, step));
                end
                m = (n < 24) ? $urandom_range(1, 2 * n) : $urandom_range(10, 40);
                repeat (m) begin
                    case ($urandom_range(0, 4))
                        0: k = any_key();
                        1: k = stored_key() + 1'b1;
                        default: k = stored_key();
                    endcase
                    send_item(srbs_pkg::OP_SEARCH, k, any_score(), any_score());
                end
            end else begin
                // random codes and unsorted keys
                repeat ($urandom_range(4, 16))
                    send_item(srbs_pkg::OP_W'($urandom_range(0, 3)),
                              ($urandom_range(0, 1) == 0) ? any_key() : stored_key(),
                              srbs_pkg::SCORE_W'($urandom_range(0, 127)),
                              srbs_pkg::SCORE_W'($urandom_range(0, 127)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = srbs_pkg::OP_CLEAR;
        i_key          = '0;
        i_first_score  = '0;
        i_second_score = '0;
        tbl_fill       = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_full_table();
        test_back_pressure();
        test_random_traffic();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        // drain outstanding results, then allow for a late extra one
        while (pending_resp.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
